>>> rtl/handshake_retry_backoff_control_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handshake retry and backoff controller
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_RETRY_BACKOFF_CONTROL_ASSERT_SVH
`define HANDSHAKE_RETRY_BACKOFF_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrbc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrbc: next-cycle check failed");

`endif

>>> rtl/hrbc_pkg.sv
// ----------------------------------------------------------------------------
// hrbc_pkg
// Types, codes and widths shared by the retry and backoff controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbc_pkg;

  localparam int TIMER_BITS = 20;
  localparam int TPS_W      = 11;
  localparam int TRY_W      = 4;
  localparam int VER_W      = 16;
  localparam int RND_W      = 16;
  localparam int CNT_W      = $clog2(RND_W);
  // The base backoff can be shifted left by up to 15 places.
  localparam int BASE_W     = TPS_W + 15;
  localparam int SUM_W      = (BASE_W + 1 > TIMER_BITS) ? BASE_W + 1 : TIMER_BITS + 1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = TPS_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_TPS       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TRIES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAP       = 2'd2;

  localparam logic [TPS_W-1:0] TPS_RESET       = 11'd128;
  localparam logic [TRY_W-1:0] MAX_TRIES_RESET = 4'd4;
  localparam logic [TRY_W-1:0] CAP_RESET       = 4'd4;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_ACK    = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_RESEND = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_NOTHING   = 3'd0,
    ST_SEND      = 3'd1,
    ST_GAVE_UP   = 3'd2,
    ST_ACK_OK    = 3'd3,
    ST_ACK_BAD   = 3'd4,
    ST_NO_PARENT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SETUP,
    S_DIV,
    S_ARM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic setup;
    logic step;
    logic arm;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic arm_now;
    logic step_last;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/handshake_retry_backoff_control.sv
// ----------------------------------------------------------------------------
// handshake_retry_backoff_control
// Initiator side of a handshake with retransmission, exponential backoff and
// random jitter on the resend countdown.
// ----------------------------------------------------------------------------
// Each input beat carries one request (start, acknowledgement, tick or forced
// resend) in in_tuser and its operands in in_tdata. Every request yields
// exactly one result beat: the status in out_tuser, the version to send and
// the retry count after the step in out_tdata.
// A request that does not arm the countdown goes from evaluation straight to
// the result register. A request that arms the countdown also runs the jitter
// modulo, one bit of random_value per cycle, 16 steps, plus setup and arming.
// One request is in flight at a time; the finished result sits in an output
// register, so the next request is taken while that result waits.
// If the receiver stalls, the block finishes the current request and holds
// in its last state until the pending result beat is taken.
// The configuration port may be written whenever no request is in flight.
// Reset restores the register defaults, sets the version to one, clears the
// retry count and flag and stops the countdown; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module handshake_retry_backoff_control import hrbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // parent_known[0], ack_version[16:1], ack_proto_ok[17], neighbor_room[18],
  // random_value[34:19], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // send_version[15:0], retry_now[19:16], zero fill above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[2:0]
  output logic [OUT_USER_W-1:0]      out_tuser
);

  `include "handshake_retry_backoff_control_assert.svh"

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  hrbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hrbc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // An accepted beat is evaluated in the very next cycle.
  `HRBC_ASSERT_NEXT(a_load_then_eval, in_tvalid && in_tready, cmd.eval)
  // A new result never overwrites one the receiver has not taken.
  `HRBC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_tvalid || out_tready)
  // No input is taken while the modulo unit is still stepping.
  `HRBC_ASSERT_SAME(a_busy_during_div, cmd.step || cmd.arm, !in_tready)

endmodule

`default_nettype wire

>>> rtl/hrbc_datapath.sv
// ----------------------------------------------------------------------------
// hrbc_datapath
// Protocol state, configuration registers, step evaluation, bit-serial jitter
// modulo, countdown arming and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbc_datapath import hrbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire ctrl_cmd_t             cmd,
  output dp_sts_t                    sts,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  logic [TPS_W-1:0]      tps_r;
  logic [TRY_W-1:0]      max_tries_r;
  logic [TRY_W-1:0]      cap_r;

  logic [VER_W-1:0]      version_r,  version_nxt;
  logic [TRY_W-1:0]      retry_r,    retry_nxt;
  logic                  ack_r,      ack_nxt;
  logic [TIMER_BITS-1:0] remain_r,   remain_nxt;
  logic                  running_r,  running_nxt;

  req_t                  kind_r;
  logic                  parent_r;
  logic [VER_W-1:0]      aver_r;
  logic                  proto_r;
  logic                  room_r;
  logic [RND_W-1:0]      dvd_r;

  status_t               res_status_r, res_status_nxt;
  logic [VER_W-1:0]      res_ver_r,    res_ver_nxt;

  logic [BASE_W-1:0]     base_r,     base_nxt;
  logic [BASE_W-1:0]     divisor_r;
  logic [RND_W-1:0]      rem_r,      rem_nxt;
  logic [CNT_W-1:0]      cnt_r;

  status_t               out_status_r;
  logic [VER_W-1:0]      out_ver_r;
  logic [TRY_W-1:0]      out_retry_r;

  logic [TIMER_BITS-1:0] dec;
  logic                  resend;
  logic [VER_W-1:0]      version_inc;
  logic                  arm;
  logic [TRY_W-1:0]      arm_retry;
  logic [TRY_W-1:0]      expo;
  logic [RND_W:0]        part;
  logic [BASE_W-1:0]     part_diff;
  logic [SUM_W-1:0]      total;
  logic [TIMER_BITS-1:0] armed;

  // Evaluation of one step against the current protocol state.
  always_comb begin
    dec         = (remain_r != '0) ? remain_r - 1'b1 : '0;
    version_inc = version_r + 1'b1;
    resend      = (kind_r == REQ_RESEND) ||
                  ((kind_r == REQ_TICK) && running_r && (dec == '0));

    version_nxt    = version_r;
    retry_nxt      = retry_r;
    ack_nxt        = ack_r;
    remain_nxt     = remain_r;
    running_nxt    = running_r;
    res_status_nxt = ST_NOTHING;
    res_ver_nxt    = '0;
    arm            = 1'b0;
    arm_retry      = '0;

    case (kind_r)
      REQ_START: begin
        if (parent_r) begin
          ack_nxt        = 1'b0;
          retry_nxt      = '0;
          version_nxt    = version_inc;
          res_ver_nxt    = version_inc;
          arm            = 1'b1;
          res_status_nxt = ST_SEND;
        end else begin
          res_status_nxt = ST_NO_PARENT;
        end
      end
      REQ_ACK: begin
        if (proto_r && room_r && (aver_r == version_r)) begin
          ack_nxt        = 1'b1;
          running_nxt    = 1'b0;
          retry_nxt      = '0;
          res_status_nxt = ST_ACK_OK;
        end else begin
          res_status_nxt = ST_ACK_BAD;
        end
      end
      REQ_TICK: begin
        if (running_r) begin
          remain_nxt = dec;
          if (dec == '0) begin
            running_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // Expiry and forced resend share the cleanup, resend and give-up path.
    if (resend) begin
      if (ack_r) begin
        running_nxt    = 1'b0;
        ack_nxt        = 1'b0;
        retry_nxt      = '0;
        res_status_nxt = ST_NOTHING;
      end else if (retry_r < max_tries_r) begin
        retry_nxt      = retry_r + 1'b1;
        version_nxt    = version_inc;
        res_ver_nxt    = version_inc;
        arm            = 1'b1;
        arm_retry      = retry_r + 1'b1;
        res_status_nxt = ST_SEND;
      end else begin
        retry_nxt      = '0;
        res_status_nxt = ST_GAVE_UP;
      end
    end

    expo     = (arm_retry < cap_r) ? arm_retry : cap_r;
    base_nxt = BASE_W'(tps_r) << expo;
  end

  // One restoring step of random_value modulo (half base + 1) per cycle.
  always_comb begin
    part      = {rem_r, dvd_r[RND_W-1]};
    part_diff = BASE_W'(part) - divisor_r;
    rem_nxt   = (BASE_W'(part) >= divisor_r) ? part_diff[RND_W-1:0] : part[RND_W-1:0];
  end

  always_comb begin
    total = SUM_W'(base_r) + SUM_W'(rem_r);
    armed = (total > SUM_W'(TIMER_MAX)) ? TIMER_MAX : total[TIMER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      max_tries_r <= MAX_TRIES_RESET;
      cap_r       <= CAP_RESET;
      version_r   <= VER_W'(1);
      retry_r     <= '0;
      ack_r       <= 1'b0;
      remain_r    <= '0;
      running_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TPS:       tps_r       <= cfg_wdata;
          CFG_MAX_TRIES: max_tries_r <= cfg_wdata[TRY_W-1:0];
          CFG_CAP:       cap_r       <= cfg_wdata[TRY_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.eval) begin
        version_r <= version_nxt;
        retry_r   <= retry_nxt;
        ack_r     <= ack_nxt;
        remain_r  <= remain_nxt;
        running_r <= running_nxt;
      end else if (cmd.arm) begin
        remain_r  <= armed;
        running_r <= 1'b1;
      end
      if (cmd.setup) begin
        cnt_r <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= req_t'(in_tuser[1:0]);
      parent_r <= in_tdata[0];
      aver_r   <= in_tdata[16:1];
      proto_r  <= in_tdata[17];
      room_r   <= in_tdata[18];
      dvd_r    <= in_tdata[34:19];
    end else if (cmd.step) begin
      dvd_r <= dvd_r << 1;
    end
    if (cmd.eval) begin
      res_status_r <= res_status_nxt;
      res_ver_r    <= res_ver_nxt;
      base_r       <= base_nxt;
    end
    if (cmd.setup) begin
      divisor_r <= (base_r >> 1) + 1'b1;
      rem_r     <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_ver_r    <= res_ver_r;
      out_retry_r  <= retry_r;
    end
  end

  assign sts.arm_now   = arm;
  assign sts.step_last = (cnt_r == '1);

  assign out_tdata = {(OUT_DATA_W - VER_W - TRY_W)'(0), out_retry_r, out_ver_r};
  assign out_tuser = out_status_r;

endmodule

`default_nettype wire

>>> rtl/hrbc_ctrl.sv
// ----------------------------------------------------------------------------
// hrbc_ctrl
// Sequencer for one item: evaluate, optional jitter modulo and countdown
// arming, then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbc_ctrl import hrbc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire dp_sts_t sts,
  output ctrl_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        // Nothing is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.arm_now ? S_SETUP : S_DONE;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_ARM;
        end
      end
      S_ARM: begin
        cmd.arm   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold here until the previous result beat has left the register.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
